### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every edge outside reset.
`define LSP_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Checked on every edge, reset included.
`define LSP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/lsp_pkg.sv
`timescale 1ns / 1ps
package lsp_pkg;

    localparam int MAX_SOURCES_DEF   = 64;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_LEN          = 24;
    localparam int SQRT_STEPS        = 32;
    localparam int DIV_STEPS         = 16;
    localparam int FIFO_DEPTH        = 4;
    localparam int FIFO_AW           = $clog2(FIFO_DEPTH);
    localparam int CORDIC_W          = 36;

    localparam logic [15:0] EIGHTH_TURN = 16'h2000;
    localparam logic [16:0] ONE_Q16     = 17'h10000;

    localparam logic [16:0] GUN_DIST_RST  = 17'd32768;
    localparam logic [15:0] SELF_DIST_RST = 16'd40;
    localparam logic [15:0] MAX_DIST_RST  = 16'd2048;

    localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef enum logic [1:0] {
        CMD_LISTENER = 2'd0,
        CMD_GUN_YAW  = 2'd1,
        CMD_SOURCE   = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        REG_GUN_DIST  = 2'd0,
        REG_SELF_DIST = 2'd1,
        REG_MAX_DIST  = 2'd2,
        REG_BED_EN    = 2'd3
    } reg_idx_t;

    typedef enum logic {
        KIND_DIRECT = 1'b0,
        KIND_SOURCE = 1'b1
    } kind_t;

    typedef struct packed {
        logic [16:0] gun_dist;
        logic [15:0] self_dist;
        logic [15:0] max_dist;
        logic        bed_en;
    } cfg_t;

    typedef struct packed {
        kind_t              kind;
        logic [6:0]         id;
        logic [15:0]        az;
        logic [16:0]        rad;
        logic               last;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [32:0] dz;
        logic [15:0]        act;
    } tok_t;

    typedef struct packed {
        logic push;
        tok_t tok;
    } push_t;

endpackage

### rtl/lsp_fifo.sv
`timescale 1ns / 1ps
module lsp_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  lsp_pkg::push_t wr,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output lsp_pkg::tok_t rd_tok
);
    import lsp_pkg::*;

    tok_t             mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [FIFO_AW:0]   cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = wr.push && !full;
    assign do_pop  = pop && !empty;
    assign rd_tok  = mem_reg[rp_reg];

    always_comb begin
        wp_next  = do_push ? wp_reg + 1'b1 : wp_reg;
        rp_next  = do_pop ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + (FIFO_AW+1)'(do_push) - (FIFO_AW+1)'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
        if (do_push) begin
            mem_reg[wp_reg] <= wr.tok;
        end
    end

endmodule

### rtl/lsp_front.sv
`timescale 1ns / 1ps
module lsp_front #(
    parameter int MAX_SOURCES = lsp_pkg::MAX_SOURCES_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [135:0]   s_tdata,
    input  logic [1:0]     s_tuser,
    input  lsp_pkg::cfg_t  cfg,
    input  logic           full,
    output lsp_pkg::push_t wr
);
    import lsp_pkg::*;

    logic [31:0] lx_reg, ly_reg, lz_reg;
    logic [15:0] lhead_reg, lock_head_reg, gun_az_reg;
    logic        locked_reg, pend_reg, pend_next;

    logic        acc;
    cmd_t        cmd;
    logic [6:0]  src_id;
    logic [31:0] px, py, pz;
    logic [15:0] head, cur;
    logic        lock;
    logic        id_ok;
    tok_t        src_tok, bed_tok;

    assign src_id = s_tdata[6:0];
    assign px     = s_tdata[38:7];
    assign py     = s_tdata[70:39];
    assign pz     = s_tdata[102:71];
    assign head   = s_tdata[118:103];
    assign cur    = s_tdata[134:119];
    assign lock   = s_tdata[135];
    assign cmd    = cmd_t'(s_tuser);

    assign s_tready = !pend_reg && !full;
    assign acc      = s_tvalid && s_tready;
    assign id_ok    = (src_id != '0) && ({1'b0, src_id} <= 8'(MAX_SOURCES));

    always_comb begin
        src_tok      = '0;
        src_tok.kind = KIND_SOURCE;
        src_tok.id   = src_id;
        src_tok.az   = gun_az_reg;
        src_tok.rad  = (cfg.gun_dist > ONE_Q16) ? ONE_Q16 : cfg.gun_dist;
        src_tok.last = 1'b1;
        src_tok.dx   = $signed({px[31], px}) - $signed({lx_reg[31], lx_reg});
        src_tok.dy   = $signed({py[31], py}) - $signed({ly_reg[31], ly_reg});
        src_tok.dz   = $signed({pz[31], pz}) - $signed({lz_reg[31], lz_reg});
        src_tok.act  = locked_reg ? lock_head_reg : lhead_reg;

        bed_tok      = '0;
        bed_tok.kind = KIND_DIRECT;
        bed_tok.rad  = ONE_Q16;
        if (pend_reg) begin
            bed_tok.id   = 7'd2;
            bed_tok.az   = gun_az_reg + EIGHTH_TURN;
            bed_tok.last = 1'b1;
        end else begin
            bed_tok.id   = 7'd1;
            bed_tok.az   = gun_az_reg - EIGHTH_TURN;
            bed_tok.last = 1'b0;
        end
    end

    always_comb begin
        wr.push  = 1'b0;
        wr.tok   = bed_tok;
        pend_next = pend_reg ? full : 1'b0;
        if (pend_reg) begin
            wr.push = 1'b1;
        end else if (acc) begin
            case (cmd)
                CMD_LISTENER: begin
                    wr.push   = cfg.bed_en;
                    pend_next = cfg.bed_en;
                end
                CMD_SOURCE: begin
                    wr.push = id_ok;
                    wr.tok  = src_tok;
                end
                default: begin
                    wr.push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lx_reg        <= '0;
            ly_reg        <= '0;
            lz_reg        <= '0;
            lhead_reg     <= '0;
            lock_head_reg <= '0;
            gun_az_reg    <= '0;
            locked_reg    <= 1'b0;
            pend_reg      <= 1'b0;
        end else begin
            pend_reg <= pend_next;
            if (acc && cmd == CMD_LISTENER) begin
                lx_reg    <= px;
                ly_reg    <= py;
                lz_reg    <= pz;
                lhead_reg <= head;
            end
            if (acc && cmd == CMD_GUN_YAW) begin
                locked_reg <= lock;
                if (lock) begin
                    lock_head_reg <= head;
                    gun_az_reg    <= head - cur;
                end else begin
                    gun_az_reg <= '0;
                end
            end
        end
    end

endmodule

### rtl/lsp_back.sv
`timescale 1ns / 1ps
module lsp_back #(
    parameter int CORDIC_STAGES = lsp_pkg::CORDIC_STAGES_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  lsp_pkg::cfg_t cfg,
    input  logic          empty,
    input  lsp_pkg::tok_t tok,
    output logic          pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [55:0]   m_tdata,
    output logic          m_tlast
);
    import lsp_pkg::*;

    localparam int P  = (CORDIC_STAGES > DIV_STEPS) ? CORDIC_STAGES : DIV_STEPS;
    localparam int CW = CORDIC_W;

    typedef struct packed {
        kind_t                kind;
        logic [6:0]           id;
        logic [15:0]          gaz;
        logic [16:0]          grad;
        logic                 last;
        logic [15:0]          act;
        logic                 self;
        logic                 big;
        logic signed [31:0]   hy;
        logic [63:0]          sv;
        logic [63:0]          sres;
        logic [63:0]          hv;
        logic [63:0]          hres;
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic [31:0]          aang;
        logic                 azero;
    } p2_t;

    typedef struct packed {
        kind_t                kind;
        logic [6:0]           id;
        logic [15:0]          gaz;
        logic [16:0]          grad;
        logic                 last;
        logic                 self;
        logic                 big;
        logic [15:0]          azim;
        logic [32:0]          drem;
        logic [15:0]          quo;
        logic signed [CW-1:0] ex;
        logic signed [CW-1:0] ey;
        logic [31:0]          eang;
        logic                 ezero;
    } p3_t;

    function automatic logic [31:0] mag33(input logic signed [32:0] v);
        logic [32:0] n;
        n = v[32] ? 33'(-v) : 33'(v);
        return n[31:0];
    endfunction

    logic en;
    logic out_vld_reg;
    logic [55:0] out_data_reg, out_data_next;
    logic out_last_reg, out_last_next;

    logic [63:0] sq_self_reg, sq_max_reg;

    logic a_vld, b_vld, c_vld;
    tok_t a_tok, b_tok;
    logic [63:0] a_x2, a_y2, a_z2, a_hx2, a_hz2;
    logic [63:0] b_sxy, b_z2, b_hs;
    logic signed [32:0] hx_w, hz_w, hy_w;
    logic [64:0] sxy_w, s_w;
    logic [63:0] s_sat;
    p2_t c_reg, c_next;

    p2_t  p2_reg [SQRT_STEPS];
    logic v2_reg [SQRT_STEPS];
    p3_t  p3_reg [P];
    logic v3_reg [P];
    p3_t  p3_in;

    assign en       = !out_vld_reg || m_tready;
    assign pop      = en && !empty;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    assign hx_w  = tok.dx >>> 1;
    assign hz_w  = tok.dz >>> 1;
    assign hy_w  = b_tok.dy >>> 1;
    assign sxy_w = {1'b0, a_x2} + {1'b0, a_y2};
    assign s_w   = {1'b0, b_sxy} + {1'b0, b_z2};
    assign s_sat = s_w[64] ? '1 : s_w[63:0];

    always_comb begin
        c_next       = '0;
        c_next.kind  = b_tok.kind;
        c_next.id    = b_tok.id;
        c_next.gaz   = b_tok.az;
        c_next.grad  = b_tok.rad;
        c_next.last  = b_tok.last;
        c_next.act   = b_tok.act;
        c_next.self  = s_sat < sq_self_reg;
        c_next.big   = (s_sat >= sq_max_reg) || (cfg.max_dist == '0);
        c_next.hy    = hy_w[31:0];
        c_next.sv    = s_sat;
        c_next.hv    = b_hs;
        c_next.azero = (b_tok.dx == '0) && (b_tok.dz == '0);
        if (b_tok.dx[32]) begin
            c_next.ax   = -{{(CW-33){b_tok.dx[32]}}, b_tok.dx};
            c_next.ay   = -{{(CW-33){b_tok.dz[32]}}, b_tok.dz};
            c_next.aang = 32'h80000000;
        end else begin
            c_next.ax   = {{(CW-33){b_tok.dx[32]}}, b_tok.dx};
            c_next.ay   = {{(CW-33){b_tok.dz[32]}}, b_tok.dz};
            c_next.aang = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld <= 1'b0;
            b_vld <= 1'b0;
            c_vld <= 1'b0;
        end else if (en) begin
            a_vld <= pop;
            b_vld <= a_vld;
            c_vld <= b_vld;
        end
        sq_self_reg <= {32'(cfg.self_dist) * 32'(cfg.self_dist), 32'd0};
        sq_max_reg  <= {32'(cfg.max_dist) * 32'(cfg.max_dist), 32'd0};
        if (en) begin
            a_tok <= tok;
            a_x2  <= 64'(mag33(tok.dx)) * 64'(mag33(tok.dx));
            a_y2  <= 64'(mag33(tok.dy)) * 64'(mag33(tok.dy));
            a_z2  <= 64'(mag33(tok.dz)) * 64'(mag33(tok.dz));
            a_hx2 <= 64'(mag33(hx_w)) * 64'(mag33(hx_w));
            a_hz2 <= 64'(mag33(hz_w)) * 64'(mag33(hz_w));
            b_tok <= a_tok;
            b_sxy <= sxy_w[64] ? '1 : sxy_w[63:0];
            b_z2  <= a_z2;
            b_hs  <= a_hx2 + a_hz2;
            c_reg <= c_next;
        end
    end

    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
        localparam logic [63:0] ONE = 64'd1 << (62 - 2 * j);
        localparam logic [31:0] ANG = ATAN_TAB[(j < ATAN_LEN) ? j : 0];
        p2_t  cur, nxt;
        logic vin;
        logic signed [CW-1:0] xs, ys;
        if (j == 0) begin : g_first
            assign cur = c_reg;
            assign vin = c_vld;
        end else begin : g_rest
            assign cur = p2_reg[j-1];
            assign vin = v2_reg[j-1];
        end
        always_comb begin
            nxt = cur;
            xs  = cur.ax >>> j;
            ys  = cur.ay >>> j;
            if (cur.sv >= cur.sres + ONE) begin
                nxt.sv   = cur.sv - (cur.sres + ONE);
                nxt.sres = (cur.sres >> 1) + ONE;
            end else begin
                nxt.sres = cur.sres >> 1;
            end
            if (cur.hv >= cur.hres + ONE) begin
                nxt.hv   = cur.hv - (cur.hres + ONE);
                nxt.hres = (cur.hres >> 1) + ONE;
            end else begin
                nxt.hres = cur.hres >> 1;
            end
            if (j < CORDIC_STAGES) begin
                if (cur.ay > 0) begin
                    nxt.ax   = cur.ax + ys;
                    nxt.ay   = cur.ay - xs;
                    nxt.aang = cur.aang + ANG;
                end else begin
                    nxt.ax   = cur.ax - ys;
                    nxt.ay   = cur.ay + xs;
                    nxt.aang = cur.aang - ANG;
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v2_reg[j] <= 1'b0;
            end else if (en) begin
                v2_reg[j] <= vin;
            end
            if (en) begin
                p2_reg[j] <= nxt;
            end
        end
    end

    always_comb begin
        p3_in       = '0;
        p3_in.kind  = p2_reg[SQRT_STEPS-1].kind;
        p3_in.id    = p2_reg[SQRT_STEPS-1].id;
        p3_in.gaz   = p2_reg[SQRT_STEPS-1].gaz;
        p3_in.grad  = p2_reg[SQRT_STEPS-1].grad;
        p3_in.last  = p2_reg[SQRT_STEPS-1].last;
        p3_in.self  = p2_reg[SQRT_STEPS-1].self;
        p3_in.big   = p2_reg[SQRT_STEPS-1].big;
        p3_in.azim  = (p2_reg[SQRT_STEPS-1].azero ? 16'd0 :
                       16'((p2_reg[SQRT_STEPS-1].aang + 32'h8000) >> 16))
                      + p2_reg[SQRT_STEPS-1].act;
        p3_in.drem  = p2_reg[SQRT_STEPS-1].sres[32:0];
        p3_in.ex    = $signed({{(CW-33){1'b0}}, p2_reg[SQRT_STEPS-1].hres[32:0]});
        p3_in.ey    = {{(CW-32){p2_reg[SQRT_STEPS-1].hy[31]}}, p2_reg[SQRT_STEPS-1].hy};
        p3_in.ezero = (p2_reg[SQRT_STEPS-1].hres == '0) && (p2_reg[SQRT_STEPS-1].hy == '0);
    end

    for (genvar j = 0; j < P; j++) begin : g_tail
        localparam int QB = (j < DIV_STEPS) ? (DIV_STEPS - 1 - j) : 0;
        localparam logic [31:0] ANG = ATAN_TAB[(j < ATAN_LEN) ? j : 0];
        p3_t  cur, nxt;
        logic vin;
        logic [32:0] dv;
        logic signed [CW-1:0] xs, ys;
        if (j == 0) begin : g_first
            assign cur = p3_in;
            assign vin = v2_reg[SQRT_STEPS-1];
        end else begin : g_rest
            assign cur = p3_reg[j-1];
            assign vin = v3_reg[j-1];
        end
        always_comb begin
            nxt = cur;
            dv  = '0;
            xs  = cur.ex >>> j;
            ys  = cur.ey >>> j;
            if (j < DIV_STEPS) begin
                dv = {17'd0, cfg.max_dist} << QB;
                if (cur.drem >= dv) begin
                    nxt.drem = cur.drem - dv;
                    nxt.quo[QB] = 1'b1;
                end
            end
            if (j < CORDIC_STAGES) begin
                if (cur.ey > 0) begin
                    nxt.ex   = cur.ex + ys;
                    nxt.ey   = cur.ey - xs;
                    nxt.eang = cur.eang + ANG;
                end else begin
                    nxt.ex   = cur.ex - ys;
                    nxt.ey   = cur.ey + xs;
                    nxt.eang = cur.eang - ANG;
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v3_reg[j] <= 1'b0;
            end else if (en) begin
                v3_reg[j] <= vin;
            end
            if (en) begin
                p3_reg[j] <= nxt;
            end
        end
    end

    always_comb begin
        logic [15:0] az, el;
        logic [16:0] rad;
        az  = p3_reg[P-1].gaz;
        el  = '0;
        rad = p3_reg[P-1].grad;
        if (p3_reg[P-1].kind == KIND_SOURCE && !p3_reg[P-1].self) begin
            az  = p3_reg[P-1].azim;
            el  = p3_reg[P-1].ezero ? 16'd0 : 16'((p3_reg[P-1].eang + 32'h8000) >> 16);
            rad = p3_reg[P-1].big ? ONE_Q16 : {1'b0, p3_reg[P-1].quo};
        end
        out_data_next = {rad, el, az, p3_reg[P-1].id};
        out_last_next = p3_reg[P-1].last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= v3_reg[P-1];
        end
        if (en) begin
            out_data_reg <= out_data_next;
            out_last_reg <= out_last_next;
        end
    end

endmodule

### rtl/listener_relative_spherical_position.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake          Payload
// s_        in         s_tvalid/s_tready  s_tdata 136 bits, s_tuser command
// m_        out        m_tvalid/m_tready  m_tdata 56 bits, m_tlast
// cfg_      in         cfg_valid/cfg_ready cfg_index 2 bits, cfg_data 17 bits
//
// One word is accepted per cycle while the queue has room; a listener update
// with the bed enabled holds off the next word until its second result is queued.
// A source result passes through the bit-serial square root and divide stages
// after it leaves the queue.
// The reset is synchronous; there is no clearing pass after it.
// A stall on the output halts the whole back pipeline; the queue lets the
// input keep accepting words until it fills.
module listener_relative_spherical_position #(
    parameter int MAX_SOURCES   = lsp_pkg::MAX_SOURCES_DEF,
    parameter int CORDIC_STAGES = lsp_pkg::CORDIC_STAGES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // source_id, pos_x, pos_y, pos_z, heading, current_yaw, lock_active
    input  logic [135:0] s_tdata,
    // command
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_id, azimuth, elevation, radius
    output logic [55:0]  m_tdata,
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [16:0]  cfg_data
);
    import lsp_pkg::*;

    cfg_t  cfg_reg;
    push_t wr;
    tok_t  rd_tok;
    logic  full, empty, pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gun_dist  <= GUN_DIST_RST;
            cfg_reg.self_dist <= SELF_DIST_RST;
            cfg_reg.max_dist  <= MAX_DIST_RST;
            cfg_reg.bed_en    <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            unique case (reg_idx_t'(cfg_index))
                REG_GUN_DIST:  cfg_reg.gun_dist  <= cfg_data;
                REG_SELF_DIST: cfg_reg.self_dist <= cfg_data[15:0];
                REG_MAX_DIST:  cfg_reg.max_dist  <= cfg_data[15:0];
                REG_BED_EN:    cfg_reg.bed_en    <= cfg_data[0];
            endcase
        end
    end

    lsp_front #(
        .MAX_SOURCES(MAX_SOURCES)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .cfg     (cfg_reg),
        .full    (full),
        .wr      (wr)
    );

    lsp_fifo u_fifo (
        .aclk   (aclk),
        .aresetn(aresetn),
        .wr     (wr),
        .full   (full),
        .pop    (pop),
        .empty  (empty),
        .rd_tok (rd_tok)
    );

    lsp_back #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .empty   (empty),
        .tok     (rd_tok),
        .pop     (pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

endmodule

### rtl/lsp_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lsp_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [135:0] s_tdata,
    input logic [1:0]   s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [55:0]  m_tdata,
    input logic         m_tlast,
    input logic         cfg_valid,
    input logic         cfg_ready,
    input logic [1:0]   cfg_index,
    input logic [16:0]  cfg_data
);

    `LSP_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "output word changed while stalled")
    `LSP_ASSERT(a_radius_max, aclk, aresetn, m_tvalid |-> m_tdata[55:39] <= 17'h10000, "radius above one")
    `LSP_ASSERT(a_first_bed, aclk, aresetn, m_tvalid && !m_tlast |-> m_tdata[6:0] == 7'd1, "non-final word is not bed slot one")
    `LSP_ASSERT_ALWAYS(a_reset_idle, aclk, $past(!aresetn) |-> !m_tvalid, "output valid right after reset")

endmodule

bind listener_relative_spherical_position lsp_checker u_lsp_checker (.*);

### tb/tb.sv
`timescale 1ns / 1ps
module tb;
    import lsp_pkg::*;

    localparam int MAXSRC = 64;
    localparam int STAGES = 16;
    localparam int LAT = 3 + 32 + 16 + 1 + 20;
    localparam longint LIMIT = 4000000;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [6:0]  id;
        logic [15:0] az;
        logic [15:0] el;
        logic [16:0] rad;
        logic        last;
    } dome_pos_t;

    typedef struct {
        cmd_t        cmd;
        logic [6:0]  id;
        logic [31:0] px, py, pz;
        logic [15:0] head, cur;
        logic        lock;
    } word_t;

    class dome_scoreboard;
        logic [16:0] gun_dist = GUN_DIST_RST;
        logic [15:0] self_dist = SELF_DIST_RST;
        logic [15:0] max_dist = MAX_DIST_RST;
        logic        bed_en = 1'b1;
        logic signed [63:0] lx, ly, lz;
        logic [15:0] lhead, lock_head, gun_az;
        logic        locked;
        dome_pos_t   pending[$];
        int          errors, checked, self_hits, bed_hits;

        function void clear_state();
            lx = 0; ly = 0; lz = 0; lhead = 0; lock_head = 0; gun_az = 0;
            locked = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [16:0] v);
            case (idx)
                REG_GUN_DIST: gun_dist = v;
                REG_SELF_DIST: self_dist = v[15:0];
                REG_MAX_DIST: max_dist = v[15:0];
                REG_BED_EN: bed_en = v[0];
            endcase
        endfunction

        function logic [63:0] root(logic [63:0] v);
            logic [63:0] r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function logic [15:0] angle_of(logic signed [63:0] x, logic signed [63:0] y);
            logic [31:0] acc;
            logic signed [63:0] xs, ys;
            acc = 0;
            if (x == 0 && y == 0) return 16'd0;
            if (x < 0) begin
                x = -x; y = -y; acc = 32'h8000_0000;
            end
            for (int i = 0; i < STAGES; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0) begin
                    x = x + ys; y = y - xs; acc = acc + ATAN_TAB[i];
                end else begin
                    x = x - ys; y = y + xs; acc = acc - ATAN_TAB[i];
                end
            end
            acc = acc + 32'h8000;
            return acc[31:16];
        endfunction

        function logic [63:0] sq(logic signed [63:0] v);
            logic [63:0] m;
            m = v < 0 ? -v : v;
            return m * m;
        endfunction

        function logic [63:0] sadd(logic [63:0] a, logic [63:0] b);
            logic [64:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[64] ? ALL_ONES : s[63:0];
        endfunction

        function void note_word(word_t w);
            logic signed [63:0] dx, dy, dz, hx, hz;
            logic [63:0] s, selfq, maxq, h;
            logic [16:0] rad;
            logic [15:0] act;
            dome_pos_t r;
            case (w.cmd)
                CMD_LISTENER: begin
                    lx = $signed(w.px); ly = $signed(w.py); lz = $signed(w.pz);
                    lhead = w.head;
                    if (bed_en) begin
                        pending.push_back('{7'd1, gun_az - EIGHTH_TURN, 16'd0, ONE_Q16, 1'b0});
                        pending.push_back('{7'd2, gun_az + EIGHTH_TURN, 16'd0, ONE_Q16, 1'b1});
                        bed_hits++;
                    end
                end
                CMD_GUN_YAW: begin
                    locked = w.lock;
                    if (!w.lock) begin
                        gun_az = 0;
                    end else begin
                        lock_head = w.head;
                        gun_az = w.head - w.cur;
                    end
                end
                CMD_SOURCE: begin
                    if (w.id == 0 || w.id > MAXSRC) return;
                    dx = $signed(w.px) - lx;
                    dy = $signed(w.py) - ly;
                    dz = $signed(w.pz) - lz;
                    s = sadd(sadd(sq(dx), sq(dy)), sq(dz));
                    selfq = (64'(self_dist) * self_dist) << 32;
                    maxq = (64'(max_dist) * max_dist) << 32;
                    if (s < selfq) begin
                        rad = gun_dist > ONE_Q16 ? ONE_Q16 : gun_dist;
                        pending.push_back('{w.id, gun_az, 16'd0, rad, 1'b1});
                        self_hits++;
                        return;
                    end
                    if (s >= maxq || max_dist == 0) rad = ONE_Q16;
                    else rad = 17'(root(s) / max_dist);
                    act = locked ? lock_head : lhead;
                    r.id = w.id;
                    r.az = angle_of(dx, dz) + act;
                    hx = dx >>> 1; hz = dz >>> 1;
                    h = root(sq(hx) + sq(hz));
                    r.el = angle_of($signed(h), dy >>> 1);
                    r.rad = rad;
                    r.last = 1'b1;
                    pending.push_back(r);
                end
                default: ;
            endcase
        endfunction

        function void check_word(dome_pos_t got);
            dome_pos_t exp_r;
            checked++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.id != exp_r.id) begin
                $display("%0t: out_id expected %0d actual %0d", $time, exp_r.id, got.id);
                errors++;
            end
            if (got.az != exp_r.az) begin
                $display("%0t: azimuth expected %h actual %h", $time, exp_r.az, got.az);
                errors++;
            end
            if (got.el != exp_r.el) begin
                $display("%0t: elevation expected %h actual %h", $time, exp_r.el, got.el);
                errors++;
            end
            if (got.rad != exp_r.rad) begin
                $display("%0t: radius expected %h actual %h", $time, exp_r.rad, got.rad);
                errors++;
            end
            if (got.last != exp_r.last) begin
                $display("%0t: last expected %b actual %b", $time, exp_r.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0, m_tready = 1'b0, cfg_valid = 1'b0;
    logic [135:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic [1:0] cfg_index = '0;
    logic [16:0] cfg_data = '0;
    logic s_tready, m_tvalid, m_tlast, cfg_ready;
    logic [55:0] m_tdata;
    longint cycles = 0;
    int rx_wait = 0;
    bit stim_done = 0;
    dome_scoreboard sb;

    listener_relative_spherical_position DUT (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAIL listener_relative_spherical_position");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_word({m_tdata[6:0], m_tdata[22:7], m_tdata[38:23], m_tdata[55:39], m_tlast});
            rx_wait <= ($urandom_range(3) == 0) ? int'($urandom_range(15)) : 0;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stim_done) begin
            m_tready <= 1'b1;
        end else if (rx_wait > 0) begin
            m_tready <= 1'b0;
            rx_wait <= rx_wait - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send(word_t w);
        int gap;
        gap = ($urandom_range(3) == 0) ? $urandom_range(15) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= w.cmd;
        s_tdata <= {w.lock, w.cur, w.head, w.pz, w.py, w.px, w.id};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_word(w);
        @(negedge aclk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [16:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.set_reg(idx, v);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (LAT) @(negedge aclk);
    endtask

    function automatic word_t mk(cmd_t c, logic [6:0] id, logic [31:0] x, logic [31:0] y,
                                 logic [31:0] z, logic [15:0] hd, logic [15:0] cu, logic lk);
        word_t w;
        w.cmd = c; w.id = id; w.px = x; w.py = y; w.pz = z;
        w.head = hd; w.cur = cu; w.lock = lk;
        return w;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(8000)) - 4000) <<< 16 | $urandom_range(65535);
            2: return 32'($signed($urandom_range(200)) - 100) <<< 16 | $urandom_range(65535);
            default: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        endcase
    endfunction

    function automatic word_t rand_word();
        int k;
        logic [6:0] id;
        k = $urandom_range(99);
        id = ($urandom_range(19) == 0) ? 7'($urandom) : 7'($urandom_range(MAXSRC, 1));
        if (k < 10) return mk(CMD_LISTENER, 7'($urandom), rand_coord(), rand_coord(),
                               rand_coord(), 16'($urandom), 16'($urandom), 1'($urandom));
        if (k < 18) return mk(CMD_GUN_YAW, 7'($urandom), $urandom, $urandom, $urandom,
                               16'($urandom), 16'($urandom), 1'($urandom));
        if (k < 20) return mk(cmd_t'(2'd3), 7'($urandom), $urandom, $urandom, $urandom,
                               16'($urandom), 16'($urandom), 1'($urandom));
        return mk(CMD_SOURCE, id, rand_coord(), rand_coord(), rand_coord(),
                  16'($urandom), 16'($urandom), 1'($urandom));
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) send(rand_word());
        drain();
    endtask

    initial begin
        sb = new();
        sb.clear_state();
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send(mk(CMD_SOURCE, 7'd5, 32'd0, 32'd0, 32'd0, 16'd0, 16'd0, 1'b0));
        send(mk(CMD_LISTENER, 7'd0, 32'h0001_0000, 32'hFFFF_0000, 32'd0, 16'h4000, 16'd0, 1'b0));
        send(mk(CMD_SOURCE, 7'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0));
        send(mk(CMD_SOURCE, 7'd64, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0));
        send(mk(CMD_SOURCE, 7'd0, 32'h0100_0000, 0, 0, 0, 0, 0));
        send(mk(CMD_SOURCE, 7'd65, 32'h0100_0000, 0, 0, 0, 0, 0));
        send(mk(CMD_SOURCE, 7'd127, 32'h0100_0000, 0, 0, 0, 0, 0));
        send(mk(CMD_GUN_YAW, 7'd0, 0, 0, 0, 16'hFFFF, 16'h1234, 1'b1));
        send(mk(CMD_LISTENER, 7'd0, 0, 0, 0, 16'h0, 0, 0));
        send(mk(CMD_SOURCE, 7'd7, 32'h0200_0000, 32'h0100_0000, 32'hFE00_0000, 0, 0, 0));
        send(mk(CMD_SOURCE, 7'd8, 32'h0000_8000, 0, 0, 0, 0, 0));
        send(mk(CMD_GUN_YAW, 7'd0, 0, 0, 0, 16'h0, 16'hFFFF, 1'b0));
        send(mk(CMD_SOURCE, 7'd9, 0, 32'h0400_0000, 0, 0, 0, 0));
        send(mk(CMD_SOURCE, 7'd10, 0, 32'hFC00_0000, 0, 0, 0, 0));
        send(mk(cmd_t'(2'd3), 7'd3, 32'h0100_0000, 0, 0, 0, 0, 0));
        drain();

        random_phase(250);
        write_reg(REG_GUN_DIST, 17'h1FFFF);
        write_reg(REG_SELF_DIST, 17'd0);
        write_reg(REG_MAX_DIST, 17'd0);
        write_reg(REG_BED_EN, 17'd0);
        random_phase(250);
        write_reg(REG_GUN_DIST, 17'd0);
        write_reg(REG_SELF_DIST, 17'hFFFF);
        write_reg(REG_MAX_DIST, 17'd1);
        write_reg(REG_BED_EN, 17'd1);
        random_phase(150);
        write_reg(REG_GUN_DIST, ONE_Q16);
        write_reg(REG_SELF_DIST, 17'd300);
        write_reg(REG_MAX_DIST, 17'hFFFF);
        random_phase(200);
        write_reg(REG_GUN_DIST, 17'd12345);
        write_reg(REG_SELF_DIST, 17'd2);
        write_reg(REG_MAX_DIST, 17'd500);
        random_phase(250);

        stim_done = 1;
        drain();
        $display("Checked %0d result words, %0d bed pairs and %0d own-sound results",
                 sb.checked, sb.bed_hits, sb.self_hits);
        $display("over five register settings and all three commands.");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("PASS listener_relative_spherical_position");
        end else begin
            $display("FAIL listener_relative_spherical_position");
        end
        $finish;
    end
endmodule
